/* rtl/dmfp_pkg.sv */
// Shared types, constants and helpers for the DNS message field parser.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package dmfp_pkg;

  // Message and name limits
  localparam int unsigned MAX_MESSAGE_BYTES = 512;
  localparam int unsigned MAX_NAME_BYTES    = 255;

  // Byte counter holds 0..MAX_MESSAGE_BYTES, name counter 0..MAX_NAME_BYTES+1
  localparam int unsigned POS_W  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned NAME_W = $clog2(MAX_NAME_BYTES + 2);
  localparam int unsigned LBL_W  = 8;

  // Job queue between front and back end
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Most result words a single input byte can cause, and index width
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Stream widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 40;

  // Field codes
  localparam logic [4:0] FC_ID      = 5'd0;
  localparam logic [4:0] FC_QR      = 5'd1;
  localparam logic [4:0] FC_OPCODE  = 5'd2;
  localparam logic [4:0] FC_AA      = 5'd3;
  localparam logic [4:0] FC_TC      = 5'd4;
  localparam logic [4:0] FC_RD      = 5'd5;
  localparam logic [4:0] FC_RA      = 5'd6;
  localparam logic [4:0] FC_RCODE   = 5'd7;
  localparam logic [4:0] FC_QDCOUNT = 5'd8;
  localparam logic [4:0] FC_ANCOUNT = 5'd9;
  localparam logic [4:0] FC_NSCOUNT = 5'd10;
  localparam logic [4:0] FC_ARCOUNT = 5'd11;
  localparam logic [4:0] FC_NAMECH  = 5'd12;
  localparam logic [4:0] FC_QTYPE   = 5'd13;
  localparam logic [4:0] FC_QCLASS  = 5'd14;
  localparam logic [4:0] FC_ATYPE   = 5'd15;
  localparam logic [4:0] FC_ACLASS  = 5'd16;
  localparam logic [4:0] FC_TTL     = 5'd17;
  localparam logic [4:0] FC_RDLEN   = 5'd18;
  localparam logic [4:0] FC_IPV4    = 5'd19;
  localparam logic [4:0] FC_ERROR   = 5'd20;
  localparam logic [4:0] FC_DONE    = 5'd21;

  // Error values and label separator
  localparam logic [31:0] ERR_NAME_LONG = 32'd1;
  localparam logic [31:0] ERR_TRUNC     = 32'd2;
  localparam logic [7:0]  CHAR_DOT      = 8'h2E;

  // What the byte itself produces
  typedef enum logic [1:0] {
    BASE_NONE  = 2'd0,
    BASE_FIELD = 2'd1,
    BASE_FLAGS = 2'd2,
    BASE_CHAR  = 2'd3
  } base_e;

  // What end of message adds after it
  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_DONE  = 2'd1,
    FIN_TRUNC = 2'd2
  } fin_e;

  // One queued job: all result words of one input byte
  typedef struct packed {
    base_e             base;
    logic              dot;      // name character closes its label
    logic [4:0]        code;
    logic [31:0]       value;
    fin_e              fin;
    logic [POS_W-1:0]  done_cnt;
  } job_t;

  // Number of result words described by a job
  function automatic logic [CNT_W-1:0] job_words(input job_t j);
    logic [CNT_W-1:0] n;
    case (j.base)
      BASE_FIELD: n = CNT_W'(1);
      BASE_FLAGS: n = CNT_W'(7);
      BASE_CHAR:  n = j.dot ? CNT_W'(2) : CNT_W'(1);
      default:    n = '0;
    endcase
    if (j.fin != FIN_NONE) n = n + CNT_W'(1);
    return n;
  endfunction

endpackage

/* rtl/dmfp_front.sv */
// Front end of the DNS message field parser: takes message bytes, tracks
// the parse position and phase, and turns each byte into a queued job.
// Depends on dmfp_pkg.
module dmfp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_message_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output dmfp_pkg::job_t q_job_o
);
  import dmfp_pkg::*;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_NAME    = 7'b0000010,
    PH_QTAIL   = 7'b0000100,
    PH_ANSWER  = 7'b0001000,
    PH_RDATA   = 7'b0010000,
    PH_SKIP    = 7'b0100000,
    PH_ERRWAIT = 7'b1000000
  } phase_e;

  phase_e             phase_q, phase_d, phase_p;
  logic [POS_W-1:0]   pos_q, pos_d, pos_p;
  logic [LBL_W-1:0]   lbl_q, lbl_d, lbl_p;
  logic [NAME_W-1:0]  nlen_q, nlen_d, nlen_p;
  logic [31:0]        acc_q, acc_d, acc_p;

  logic        accept;
  logic        parse;
  logic [31:0] acc_n;
  logic [15:0] w;
  job_t        job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign parse      = (pos_q < POS_W'(MAX_MESSAGE_BYTES));
  assign acc_n      = {acc_q[23:0], data_byte_i};
  assign w          = acc_n[15:0];

  // Per-byte parse step
  always_comb begin
    phase_p  = phase_q;
    pos_p    = pos_q;
    lbl_p    = lbl_q;
    nlen_p   = nlen_q;
    acc_p    = acc_q;
    job      = '0;
    job.base = BASE_NONE;
    job.fin  = FIN_NONE;

    if (parse) begin
      acc_p = acc_n;
      pos_p = pos_q + POS_W'(1);
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q == POS_W'(1)) begin
            job.base = BASE_FIELD; job.code = FC_ID; job.value = 32'(w);
          end else if (pos_q == POS_W'(3)) begin
            job.base = BASE_FLAGS; job.value = 32'(w);
          end else if (pos_q == POS_W'(5)) begin
            job.base = BASE_FIELD; job.code = FC_QDCOUNT; job.value = 32'(w);
          end else if (pos_q == POS_W'(7)) begin
            job.base = BASE_FIELD; job.code = FC_ANCOUNT; job.value = 32'(w);
          end else if (pos_q == POS_W'(9)) begin
            job.base = BASE_FIELD; job.code = FC_NSCOUNT; job.value = 32'(w);
          end else if (pos_q == POS_W'(11)) begin
            job.base = BASE_FIELD; job.code = FC_ARCOUNT; job.value = 32'(w);
            phase_p  = PH_NAME;
            lbl_p    = '0;
            nlen_p   = '0;
          end
        end
        PH_NAME: begin
          nlen_p = nlen_q + NAME_W'(1);
          if (nlen_p > NAME_W'(MAX_NAME_BYTES)) begin
            job.base  = BASE_FIELD;
            job.code  = FC_ERROR;
            job.value = ERR_NAME_LONG;
            phase_p   = PH_ERRWAIT;
          end else if (lbl_q == '0) begin
            // length byte; a zero length ends the name
            if (data_byte_i == 8'd0) begin
              phase_p = PH_QTAIL;
              lbl_p   = '0;
            end else begin
              lbl_p = data_byte_i;
            end
          end else begin
            job.base  = BASE_CHAR;
            job.code  = FC_NAMECH;
            job.value = 32'(data_byte_i);
            job.dot   = (lbl_q == LBL_W'(1));
            lbl_p     = lbl_q - LBL_W'(1);
          end
        end
        PH_QTAIL: begin
          if (lbl_q == LBL_W'(3)) begin
            job.base = BASE_FIELD; job.code = FC_QCLASS; job.value = 32'(w);
            phase_p  = PH_ANSWER;
            lbl_p    = '0;
          end else begin
            if (lbl_q == LBL_W'(1)) begin
              job.base = BASE_FIELD; job.code = FC_QTYPE; job.value = 32'(w);
            end
            lbl_p = lbl_q + LBL_W'(1);
          end
        end
        PH_ANSWER: begin
          if (lbl_q == LBL_W'(11)) begin
            job.base = BASE_FIELD; job.code = FC_RDLEN; job.value = 32'(w);
            phase_p  = (w == 16'd4) ? PH_RDATA : PH_SKIP;
            lbl_p    = '0;
          end else begin
            if (lbl_q == LBL_W'(3)) begin
              job.base = BASE_FIELD; job.code = FC_ATYPE; job.value = 32'(w);
            end else if (lbl_q == LBL_W'(5)) begin
              job.base = BASE_FIELD; job.code = FC_ACLASS; job.value = 32'(w);
            end else if (lbl_q == LBL_W'(9)) begin
              job.base = BASE_FIELD; job.code = FC_TTL; job.value = acc_n;
            end
            lbl_p = lbl_q + LBL_W'(1);
          end
        end
        PH_RDATA: begin
          if (lbl_q == LBL_W'(3)) begin
            job.base = BASE_FIELD; job.code = FC_IPV4; job.value = acc_n;
            phase_p  = PH_SKIP;
            lbl_p    = '0;
          end else begin
            lbl_p = lbl_q + LBL_W'(1);
          end
        end
        default: ;
      endcase
    end

    // End of message: report and return to the start state
    job.done_cnt = pos_p;
    if (end_of_message_i) begin
      if (phase_p == PH_ERRWAIT) begin
        job.fin = FIN_NONE;
      end else if (phase_p == PH_SKIP || (phase_p == PH_ANSWER && lbl_p == '0)) begin
        job.fin = FIN_DONE;
      end else begin
        job.fin = FIN_TRUNC;
      end
      phase_d = PH_HEADER;
      pos_d   = '0;
      lbl_d   = '0;
      nlen_d  = '0;
      acc_d   = '0;
    end else begin
      phase_d = phase_p;
      pos_d   = pos_p;
      lbl_d   = lbl_p;
      nlen_d  = nlen_p;
      acc_d   = acc_p;
    end
  end

  assign q_job_o  = job;
  assign q_push_o = accept && ((job.base != BASE_NONE) || (job.fin != FIN_NONE));

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      lbl_q   <= '0;
      nlen_q  <= '0;
      acc_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      lbl_q   <= lbl_d;
      nlen_q  <= nlen_d;
      acc_q   <= acc_d;
    end
  end

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_MESSAGE_BYTES))
    else $error("byte position beyond message limit");

  a_header_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (pos_q >= POS_W'(12)))
    else $error("left header phase before twelve bytes");

  a_eom_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_message_i) |=> (phase_q == PH_HEADER && pos_q == '0))
    else $error("state not cleared after end of message");

endmodule

/* rtl/dmfp_fifo.sv */
// Short job queue between the parser front end and the result back end.
// Holds FIFO_DEPTH jobs in registers. Depends on dmfp_pkg.
module dmfp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dmfp_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dmfp_pkg::job_t head_o
);
  import dmfp_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wptr_q, rptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_job_i;
  end

  // Head word, straight from the register slot at the read pointer
  assign head_o = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + FIFO_PW'(1);
      if (do_pop)  rptr_q <= rptr_q + FIFO_PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + FIFO_CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - FIFO_CW'(1);
    end
  end

endmodule

/* rtl/dmfp_back.sv */
// Back end of the DNS message field parser: expands each queued job into
// its result words, one per cycle unless the output stalls, into a
// registered output stage. Depends on dmfp_pkg.
module dmfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dmfp_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [4:0]     field_code_o,
  output logic [31:0]    field_value_o,
  output logic           last_of_run_o
);
  import dmfp_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             vld_q;
  logic [4:0]       code_q, code_c;
  logic [31:0]      val_q, val_c;
  logic             last_q, last_c;
  logic [CNT_W-1:0] n_words, n_base;
  logic             load;
  logic [15:0]      w;

  assign n_words = job_words(job_i);
  assign n_base  = (job_i.fin != FIN_NONE) ? n_words - CNT_W'(1) : n_words;
  assign w       = job_i.value[15:0];
  assign last_c  = (CNT_W'(idx_q) + CNT_W'(1) == n_words);
  assign load    = job_valid_i && (!vld_q || out_ready_i);

  // Select the word at the current index of the head job
  always_comb begin
    code_c = job_i.code;
    val_c  = job_i.value;
    if (CNT_W'(idx_q) < n_base) begin
      case (job_i.base)
        BASE_FLAGS: begin
          code_c = FC_QR + 5'(idx_q);
          case (idx_q)
            IDX_W'(0): val_c = 32'(w[15]);
            IDX_W'(1): val_c = 32'(w[14:11]);
            IDX_W'(2): val_c = 32'(w[10]);
            IDX_W'(3): val_c = 32'(w[9]);
            IDX_W'(4): val_c = 32'(w[8]);
            IDX_W'(5): val_c = 32'(w[7]);
            default:   val_c = 32'(w[3:0]);
          endcase
        end
        BASE_CHAR: begin
          code_c = FC_NAMECH;
          val_c  = (idx_q == '0) ? job_i.value : 32'(CHAR_DOT);
        end
        default: ;
      endcase
    end else if (job_i.fin == FIN_DONE) begin
      code_c = FC_DONE;
      val_c  = 32'(job_i.done_cnt);
    end else begin
      code_c = FC_ERROR;
      val_c  = ERR_TRUNC;
    end
  end

  assign job_pop_o = load && last_c;
  assign idx_d     = job_pop_o ? '0 : (load ? idx_q + IDX_W'(1) : idx_q);

  // Word index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load)             vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= code_c;
      val_q  <= val_c;
      last_q <= last_c;
    end
  end

  assign out_valid_o   = vld_q;
  assign field_code_o  = code_q;
  assign field_value_o = val_q;
  assign last_of_run_o = last_q;

  // Checks
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (CNT_W'(idx_q) < n_words))
    else $error("word index past end of job");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> (idx_q == '0))
    else $error("word index not at start with empty queue");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (code_q <= FC_DONE))
    else $error("result code out of range");

endmodule

/* rtl/dns_message_field_parser_top.sv */
// Top level of the DNS message field parser: front end, job queue and back end.
// Depends on dmfp_pkg, dmfp_front, dmfp_fifo and dmfp_back.
//
// Takes a DNS message one byte per word on the slave stream (tlast on the
// final byte) and returns tagged fields on the master stream: the header
// fields, the first question's name characters with a dot after each label,
// qtype, qclass, and the first answer's type, class, ttl, rdlength and IPv4
// address, then done (with the byte count) or an error word. tlast on the
// master side marks the last word caused by one input byte. A byte is taken
// every cycle while the four-entry job queue has room; each byte makes zero to
// eight result words, and the output register sends one word per cycle while
// the master side is ready, so the header flags byte (seven words) and bytes
// closing a message hold the input back when the queue fills. A byte's job
// is queued, then its first word registered. No start-up pass after reset.
module dns_message_field_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] field_code, [36:5] field_value, rest zero
  output logic        m_axis_tlast    // last_of_run
);
  import dmfp_pkg::*;

  job_t        push_job, head_job;
  logic        push, full, head_valid, pop;
  logic [4:0]  field_code;
  logic [31:0] field_value;

  dmfp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .data_byte_i      (s_axis_tdata),
    .end_of_message_i (s_axis_tlast),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_job_o          (push_job)
  );

  dmfp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_job)
  );

  dmfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .field_code_o  (field_code),
    .field_value_o (field_value),
    .last_of_run_o (m_axis_tlast)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = {3'b000, field_value, field_code};

endmodule

/* sim/testbench.sv */
// Self-checking testbench for dns_message_field_parser_top: streams DNS messages in byte
// by byte, predicts every field word and checks the master stream against it.
// Depends on dmfp_pkg and the RTL of the parser.
module testbench;
  import dmfp_pkg::*;

  // Phases of the field decoder held in the testbench
  typedef enum logic [2:0] {
    PH_HEADER, PH_QNAME, PH_QTAIL, PH_ANSWER, PH_RDATA, PH_SKIP, PH_ERRWAIT
  } phase_e;

  // One input word, or a pause marker that waits for all fields to drain
  typedef struct {
    logic [7:0] data;
    logic       eom;
    logic       pause;
  } byte_item_t;

  // One expected result word
  typedef struct {
    logic [4:0]  code;
    logic [31:0] value;
    logic        last;
  } field_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  byte_item_t  bytes_pending[$];
  field_t      fields_due[$];
  field_t      run_fields[$];
  logic [7:0]  msg_bytes[$];

  int unsigned mismatches  = 0;
  int unsigned words_seen  = 0;
  int unsigned bytes_queued = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_left  = 0;
  logic        stall_done  = 1'b0;
  byte_item_t  drv_item;
  field_t      mon_field;

  // Decoder state
  phase_e           ph;
  logic [POS_W-1:0] pos;
  logic [7:0]       lbl;
  logic [NAME_W-1:0] nlen;
  logic [31:0]      acc;
  logic [15:0]      rdlen;

  dns_message_field_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Field decoder

  task automatic clear_decoder();
    ph    = PH_HEADER;
    pos   = '0;
    lbl   = '0;
    nlen  = '0;
    acc   = '0;
    rdlen = '0;
  endtask

  task automatic add_field(input logic [4:0] code, input logic [31:0] value);
    field_t f;
    f.code  = code;
    f.value = value;
    f.last  = 1'b0;
    run_fields.push_back(f);
  endtask

  // Parse one byte of a message within the byte budget
  task automatic parse_msg_byte(input logic [7:0] b);
    logic [15:0] w;
    acc = {acc[23:0], b};
    w   = acc[15:0];
    case (ph)
      PH_HEADER: begin
        if (pos == 1) add_field(FC_ID, 32'(w));
        else if (pos == 3) begin
          add_field(FC_QR,     32'(w[15]));
          add_field(FC_OPCODE, 32'(w[14:11]));
          add_field(FC_AA,     32'(w[10]));
          add_field(FC_TC,     32'(w[9]));
          add_field(FC_RD,     32'(w[8]));
          add_field(FC_RA,     32'(w[7]));
          add_field(FC_RCODE,  32'(w[3:0]));
        end else if (pos == 5) add_field(FC_QDCOUNT, 32'(w));
        else if (pos == 7) add_field(FC_ANCOUNT, 32'(w));
        else if (pos == 9) add_field(FC_NSCOUNT, 32'(w));
        else if (pos == 11) begin
          add_field(FC_ARCOUNT, 32'(w));
          ph   = PH_QNAME;
          lbl  = '0;
          nlen = '0;
        end
      end
      PH_QNAME: begin
        nlen = nlen + 1'b1;
        if (nlen > NAME_W'(MAX_NAME_BYTES)) begin
          add_field(FC_ERROR, ERR_NAME_LONG);
          ph = PH_ERRWAIT;
        end else if (lbl == 0) begin
          // a length byte, even with its top bits set, opens a plain label
          if (b == 8'h00) ph = PH_QTAIL;
          else lbl = b;
        end else begin
          add_field(FC_NAMECH, 32'(b));
          lbl = lbl - 1'b1;
          if (lbl == 0) add_field(FC_NAMECH, 32'(CHAR_DOT));
        end
      end
      PH_QTAIL: begin
        if (lbl == 3) begin
          add_field(FC_QCLASS, 32'(w));
          ph  = PH_ANSWER;
          lbl = '0;
        end else begin
          if (lbl == 1) add_field(FC_QTYPE, 32'(w));
          lbl = lbl + 1'b1;
        end
      end
      PH_ANSWER: begin
        if (lbl == 11) begin
          rdlen = w;
          add_field(FC_RDLEN, 32'(w));
          ph  = (w == 16'd4) ? PH_RDATA : PH_SKIP;
          lbl = '0;
        end else begin
          if (lbl == 3) add_field(FC_ATYPE, 32'(w));
          else if (lbl == 5) add_field(FC_ACLASS, 32'(w));
          else if (lbl == 9) add_field(FC_TTL, acc);
          lbl = lbl + 1'b1;
        end
      end
      PH_RDATA: begin
        if (lbl == 3) begin
          add_field(FC_IPV4, acc);
          ph  = PH_SKIP;
          lbl = '0;
        end else lbl = lbl + 1'b1;
      end
      default: ;
    endcase
  endtask

  // All fields caused by one accepted byte, tlast on the final one
  task automatic decode_byte(input logic [7:0] b, input logic eom);
    field_t f;
    run_fields.delete();
    if (pos < POS_W'(MAX_MESSAGE_BYTES)) begin
      parse_msg_byte(b);
      pos = pos + 1'b1;
    end
    if (eom) begin
      if (ph == PH_ERRWAIT) begin
        // error already reported
      end else if (ph == PH_SKIP || (ph == PH_ANSWER && lbl == 0)) begin
        add_field(FC_DONE, 32'(pos));
      end else begin
        add_field(FC_ERROR, ERR_TRUNC);
      end
      clear_decoder();
    end
    foreach (run_fields[i]) begin
      f      = run_fields[i];
      f.last = (i == run_fields.size() - 1);
      fields_due.push_back(f);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Message building

  task automatic put8(input logic [7:0] b);
    msg_bytes.push_back(b);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] cnt);
    put16(id);
    put16(flags);
    repeat (4) put16(cnt);
  endtask

  task automatic put_rand_header();
    put16(16'($urandom));
    put16(16'($urandom));
    repeat (4) put16(16'($urandom));
  endtask

  // Question name of random labels, terminator, qtype and qclass
  task automatic put_question(input int n_labels, input int max_len);
    int len;
    for (int l = 0; l < n_labels; l++) begin
      len = $urandom_range(max_len, 1);
      put8(8'(len));
      repeat (len) put8(8'($urandom_range(255)));
    end
    put8(8'h00);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_answer(input logic [15:0] rdl, input int n_data);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rdl);
    repeat (n_data) put8(8'($urandom_range(255)));
  endtask

  // Queue the first n bytes of the message (all when n is 0), tlast on the last
  task automatic send_msg(input int n);
    byte_item_t it;
    int cnt;
    cnt = (n == 0 || n > msg_bytes.size()) ? msg_bytes.size() : n;
    for (int i = 0; i < cnt; i++) begin
      it.data  = msg_bytes[i];
      it.eom   = (i == cnt - 1);
      it.pause = 1'b0;
      bytes_pending.push_back(it);
    end
    bytes_queued += cnt;
    msg_bytes.delete();
  endtask

  task automatic send_pause();
    byte_item_t it;
    it.data  = 8'h00;
    it.eom   = 1'b0;
    it.pause = 1'b1;
    bytes_pending.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting

  task automatic flag_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] want);
    $display("mismatch %0d: %s got %h want %h", words_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Cycle count, used for the stretch with no idling

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic idle_now();
    return ($urandom_range(99) < 11) && !(cycle_cnt >= 400 && cycle_cnt < 900);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (s_axis_tvalid && !s_axis_tready) begin
        // word held until taken
      end else if (bytes_pending.size() > 0 && bytes_pending[0].pause) begin
        if (fields_due.size() == 0) void'(bytes_pending.pop_front());
        s_axis_tvalid <= 1'b0;
      end else if (bytes_pending.size() > 0 && !idle_now()) begin
        drv_item = bytes_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drv_item.data;
        s_axis_tlast  <= drv_item.eom;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, once, to fill the job queue

  always @(posedge clk_i) begin
    if (!stall_done && words_seen >= 150) begin
      stall_left <= 150;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_left == 0) && !idle_now();
      if (m_axis_tvalid && m_axis_tready) begin
        if (fields_due.size() == 0) begin
          flag_mismatch("word with nothing due", m_axis_tdata, 40'h0);
        end else begin
          mon_field = fields_due.pop_front();
          if (m_axis_tdata[4:0] !== mon_field.code)
            flag_mismatch("field_code", 40'(m_axis_tdata[4:0]), 40'(mon_field.code));
          if (m_axis_tdata[36:5] !== mon_field.value)
            flag_mismatch("field_value", 40'(m_axis_tdata[36:5]), 40'(mon_field.value));
          if (m_axis_tdata[39:37] !== 3'b000)
            flag_mismatch("tdata padding", 40'(m_axis_tdata[39:37]), 40'h0);
          if (m_axis_tlast !== mon_field.last)
            flag_mismatch("last_of_run", 40'(m_axis_tlast), 40'(mon_field.last));
        end
        words_seen <= words_seen + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run

  initial begin
    int kind;
    int rdl;
    int n_msgs;
    int budget;
    clear_decoder();

    // all ones in header and question, one-character name, IPv4 answer
    put_header(16'hFFFF, 16'hFFFF, 16'hFFFF);
    put8(8'h01); put8(8'hFF); put8(8'h00);
    put16(16'hFFFF); put16(16'hFFFF);
    put_answer(16'd4, 4);
    send_msg(0);
    // all zeros, empty name, ends at the start of the answer section
    put_header(16'h0000, 16'h0000, 16'h0000);
    put8(8'h00);
    put16(16'h0000); put16(16'h0000);
    send_msg(0);
    // opcode alone set, then a lone byte message that is truncated at once
    put_header(16'h1234, 16'h7800, 16'h0001);
    put_question(2, 3);
    put_answer(16'd0, 0);
    repeat (3) put8(8'($urandom_range(255)));
    send_msg(0);
    put8(8'hA5);
    send_msg(0);
    // qr alone set, truncated inside the rdata
    put_header(16'h8001, 16'h8000, 16'h0100);
    put_question(1, 4);
    put_answer(16'd4, 4);
    send_msg(msg_bytes.size() - 2);
    // label length with top bits set, name grows past its limit
    put_header(16'h5A5A, 16'h5A5A, 16'hA5A5);
    put8(8'hC1);
    repeat (193) put8(8'($urandom_range(255)));
    put8(8'h3F);
    repeat (63) put8(8'($urandom_range(255)));
    repeat (4) put8(8'($urandom_range(255)));
    send_msg(0);
    // message longer than the byte budget
    put_rand_header();
    put_question(1, 5);
    put_answer(16'h0300, 520);
    send_msg(0);
    send_pause();

    // random messages, mostly well formed
    budget = bytes_queued + 350;
    n_msgs = 0;
    while (bytes_queued < budget) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        put_rand_header();
        put_question($urandom_range(3), $urandom_range(12, 1));
        if (kind < 10) begin
          send_msg(0);
        end else begin
          rdl = ($urandom_range(9) < 7) ? 4 : $urandom_range(6);
          put_answer(16'(rdl), rdl);
          repeat ($urandom_range(3)) put8(8'($urandom_range(255)));
          send_msg((kind < 55) ? 0 : $urandom_range(msg_bytes.size(), 1));
        end
      end else begin
        repeat ($urandom_range(16, 1)) put8(8'($urandom_range(255)));
        send_msg(0);
      end
      n_msgs++;
      if (n_msgs % 8 == 0) send_pause();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (fields_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && fields_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* dns_message_field_parser_top.f */
rtl/dmfp_pkg.sv
rtl/dmfp_front.sv
rtl/dmfp_fifo.sv
rtl/dmfp_back.sv
rtl/dns_message_field_parser_top.sv
sim/testbench.sv
